### rtl/qer_pkg.sv
package qer_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // product and sum widths of the polynomial datapath
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = 3 * DATA_WIDTH + 2;
    localparam int FL_W   = SUM_W - 2 * FRAC_BITS;

    // discriminant, square root and divider widths
    localparam int DISC_W = 2 * DATA_WIDTH + 2;
    localparam int SQ_N   = DISC_W / 2;
    localparam int ROOT_W = SQ_N;
    localparam int SREM_W = DATA_WIDTH + 3;
    localparam int NUM_W  = DATA_WIDTH + 2 + FRAC_BITS;
    localparam int DEN_W  = DATA_WIDTH + 1;
    localparam int DREM_W = DATA_WIDTH + 2;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTANT = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ROOTS_TWO    = 2'd0;
    localparam status_t ROOTS_DOUBLE = 2'd1;
    localparam status_t ROOTS_NONE   = 2'd2;
    localparam status_t ROOTS_DEGEN  = 2'd3;

    typedef struct packed {
        status_t                       status;
        logic signed [DATA_WIDTH-1:0]  plus;
        logic signed [DATA_WIDTH-1:0]  minus;
        logic                          saturated;
    } roots_t;

endpackage

### rtl/qer_in_if.sv
interface qer_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qer_pkg::DATA_WIDTH-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

### rtl/qer_out_if.sv
interface qer_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qer_pkg::DATA_WIDTH-1:0] poly_value;
    logic                                  value_saturated;
    logic [1:0]                            root_status;
    logic signed [qer_pkg::DATA_WIDTH-1:0] root_plus;
    logic signed [qer_pkg::DATA_WIDTH-1:0] root_minus;
    logic                                  root_saturated;

    modport source (output valid, output poly_value, output value_saturated,
                    output root_status, output root_plus, output root_minus,
                    output root_saturated, input ready);
    modport sink (input valid, input poly_value, input value_saturated,
                  input root_status, input root_plus, input root_minus,
                  input root_saturated, output ready);
endinterface

### rtl/quadratic_eval_and_roots_core.sv
// quadratic evaluator with root finder, signed Q16.16
// config: cfg_we/cfg_index/cfg_data write a (index 0), b (1) and c (2);
//   other indexes are ignored. write only while no word is in flight
// in_ch: one x per word; out_ch: one result word per input word, in order
// pipeline: out_ch.valid is registered through four register stages
//   (v1, v2, v3, out_valid); one word per cycle while not stalled or solving
// roots depend on the coefficients only: after every config write a
//   sequential solver (discriminant, bit-serial square root, bit-serial
//   divider) runs, stopping after the discriminant when a is zero or the
//   discriminant is negative; while it runs in_ch.ready is low
// reset: coefficients clear to zero, the pipeline empties, roots read
//   as the degenerate case and the block is ready at once
// stall: a valid output word holds while out_ch.ready is low, and every
//   stage holds with it; in_ch.ready drops, so nothing is lost
module quadratic_eval_and_roots_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    qer_in_if.sink                                 in_ch,
    qer_out_if.source                              out_ch,
    input  logic                                   cfg_we,
    input  logic [qer_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [qer_pkg::DATA_WIDTH-1:0]         cfg_data
);

    localparam int DW = qer_pkg::DATA_WIDTH;
    localparam int FB = qer_pkg::FRAC_BITS;

    logic signed [DW-1:0] coef_square_reg, coef_linear_reg, coef_constant_reg;

    logic                                 adv, in_acc, solve_busy;
    qer_pkg::roots_t                      roots;

    logic                                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic signed [qer_pkg::PROD_W-1:0]    ax_reg, ax_next, bx_reg, bx_next;
    logic signed [DW-1:0]                 x1_reg;
    logic signed [qer_pkg::PROD_W:0]      plo_reg, plo_next;
    logic signed [qer_pkg::PROD_W-1:0]    phi_reg, phi_next;
    logic signed [qer_pkg::SUM_W-1:0]     bxc_reg, bxc_next, sum_reg, sum_next;
    logic signed [qer_pkg::FL_W-1:0]      fl;
    logic signed [DW-1:0]                 poly_reg, poly_next;
    logic                                 vsat_reg, vsat_next;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv && !solve_busy && !cfg_we;
    assign in_acc      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_square_reg   <= '0;
            coef_linear_reg   <= '0;
            coef_constant_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qer_pkg::REG_SQUARE:   coef_square_reg   <= cfg_data;
                qer_pkg::REG_LINEAR:   coef_linear_reg   <= cfg_data;
                qer_pkg::REG_CONSTANT: coef_constant_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    qer_solver u_solver (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we),
        .coef_a (coef_square_reg),
        .coef_b (coef_linear_reg),
        .coef_c (coef_constant_reg),
        .busy   (solve_busy),
        .roots  (roots)
    );

    always_comb
    begin
        ax_next  = coef_square_reg * in_ch.x_value;
        bx_next  = coef_linear_reg * in_ch.x_value;
        // a*x split into an unsigned low half and a signed high half
        plo_next = $signed({1'b0, ax_reg[DW-1:0]}) * x1_reg;
        phi_next = $signed(ax_reg[qer_pkg::PROD_W-1:DW]) * x1_reg;
        bxc_next = (qer_pkg::SUM_W'(bx_reg) <<< FB)
                 + (qer_pkg::SUM_W'(coef_constant_reg) <<< (2 * FB));
        sum_next = (qer_pkg::SUM_W'(phi_reg) <<< DW) + qer_pkg::SUM_W'(plo_reg) + bxc_reg;
        fl       = sum_reg[qer_pkg::SUM_W-1:2*FB];
        if ((fl[qer_pkg::FL_W-1:DW-1] == '0) || (fl[qer_pkg::FL_W-1:DW-1] == '1))
        begin
            poly_next = fl[DW-1:0];
            vsat_next = 1'b0;
        end
        else
        begin
            poly_next = fl[qer_pkg::FL_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                            : {1'b0, {(DW-1){1'b1}}};
            vsat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_acc;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg   <= ax_next;
            bx_reg   <= bx_next;
            x1_reg   <= in_ch.x_value;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            bxc_reg  <= bxc_next;
            sum_reg  <= sum_next;
            poly_reg <= poly_next;
            vsat_reg <= vsat_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.poly_value      = poly_reg;
    assign out_ch.value_saturated = vsat_reg;
    assign out_ch.root_status     = roots.status;
    assign out_ch.root_plus       = roots.plus;
    assign out_ch.root_minus      = roots.minus;
    assign out_ch.root_saturated  = roots.saturated;

    a_no_accept_while_solving: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !solve_busy)
        else $error("word accepted while roots are being solved");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> ($stable(v1_reg) && $stable(v2_reg)
                                              && $stable(v3_reg)))
        else $error("pipeline moved during output stall");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.root_status == qer_pkg::ROOTS_DEGEN
                          || out_ch.root_status == qer_pkg::ROOTS_NONE))
        |-> (out_ch.root_plus == '0 && out_ch.root_minus == '0 && !out_ch.root_saturated))
        else $error("roots reported without real solution");

    a_double_minus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.root_status == qer_pkg::ROOTS_DOUBLE)
        |-> (out_ch.root_minus == '0))
        else $error("second root nonzero for double root");

endmodule

### rtl/qer_solver.sv
module qer_solver (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [qer_pkg::DATA_WIDTH-1:0] coef_a,
    input  logic signed [qer_pkg::DATA_WIDTH-1:0] coef_b,
    input  logic signed [qer_pkg::DATA_WIDTH-1:0] coef_c,
    output logic                                  busy,
    output qer_pkg::roots_t                       roots
);

    localparam int DW = qer_pkg::DATA_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DISC = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [qer_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [qer_pkg::PROD_W-1:0]   bb_reg, bb_next, ac_reg, ac_next;
    logic [qer_pkg::DISC_W-1:0]          rad_reg, rad_next;
    logic [qer_pkg::SREM_W-1:0]          srem_reg, srem_next;
    logic [qer_pkg::ROOT_W-1:0]          root_reg, root_next;
    logic                                dzero_reg, dzero_next;
    logic [qer_pkg::NUM_W-1:0]           nump_reg, nump_next, numm_reg, numm_next;
    logic [qer_pkg::DREM_W-1:0]          remp_reg, remp_next, remm_reg, remm_next;
    logic [qer_pkg::DEN_W-1:0]           den_reg, den_next;
    logic                                negp_reg, negp_next, negm_reg, negm_next;
    qer_pkg::roots_t                     roots_reg, roots_next;

    logic signed [qer_pkg::DISC_W-1:0]   disc;
    logic [qer_pkg::SREM_W-1:0]          srem_sh, strial;
    logic signed [DW+2:0]                diff_p, diff_m;
    logic [DW+1:0]                       mag_p, mag_m;
    logic [DW-1:0]                       a_abs;
    logic [qer_pkg::DREM_W-1:0]          remp_sh, remm_sh;
    logic                                qp, qm;
    logic [DW-1:0]                       sat_p, sat_m;
    logic                                clip_p, clip_m;

    function automatic logic [DW:0] sat_quot(input logic [qer_pkg::NUM_W-1:0] q,
                                             input logic neg);
        logic                   big;
        logic                   edge_min;
        logic [DW-1:0]          val;
        logic                   clip;
        big      = |q[qer_pkg::NUM_W-1:DW-1];
        edge_min = (q[qer_pkg::NUM_W-1:DW-1] == {{(qer_pkg::NUM_W-DW){1'b0}}, 1'b1})
                   && (q[DW-2:0] == '0);
        val      = neg ? (~q[DW-1:0] + 1'b1) : q[DW-1:0];
        clip     = neg ? (big && !edge_min) : big;
        if (clip)
        begin
            val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return {clip, val};
    endfunction

    always_comb
    begin
        disc   = (qer_pkg::DISC_W'(bb_reg)) - (qer_pkg::DISC_W'(ac_reg) <<< 2);
        srem_sh = {srem_reg[qer_pkg::SREM_W-3:0], rad_reg[qer_pkg::DISC_W-1 -: 2]};
        strial  = {root_reg, 2'b01};
        diff_p = $signed({2'b00, root_reg}) - (DW+3)'(coef_b);
        diff_m = -(DW+3)'(coef_b) - $signed({2'b00, root_reg});
        mag_p  = diff_p[DW+2] ? (DW+2)'(-diff_p) : diff_p[DW+1:0];
        mag_m  = diff_m[DW+2] ? (DW+2)'(-diff_m) : diff_m[DW+1:0];
        a_abs  = coef_a[DW-1] ? DW'(-coef_a) : coef_a;
        remp_sh = {remp_reg[DW:0], nump_reg[qer_pkg::NUM_W-1]};
        remm_sh = {remm_reg[DW:0], numm_reg[qer_pkg::NUM_W-1]};
        qp = remp_sh >= qer_pkg::DREM_W'(den_reg);
        qm = remm_sh >= qer_pkg::DREM_W'(den_reg);
        {clip_p, sat_p} = sat_quot(nump_reg, negp_reg);
        {clip_m, sat_m} = sat_quot(numm_reg, negm_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bb_next    = bb_reg;
        ac_next    = ac_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        dzero_next = dzero_reg;
        nump_next  = nump_reg;
        numm_next  = numm_reg;
        remp_next  = remp_reg;
        remm_next  = remm_reg;
        den_next   = den_reg;
        negp_next  = negp_reg;
        negm_next  = negm_reg;
        roots_next = roots_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_MUL:
            begin
                bb_next    = coef_b * coef_b;
                ac_next    = coef_a * coef_c;
                state_next = S_DISC;
            end
            S_DISC:
            begin
                rad_next   = disc;
                dzero_next = (disc == '0);
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = '0;
                roots_next = '0;
                if (coef_a == '0)
                begin
                    roots_next.status = qer_pkg::ROOTS_DEGEN;
                    state_next = S_IDLE;
                end
                else if (disc[qer_pkg::DISC_W-1])
                begin
                    roots_next.status = qer_pkg::ROOTS_NONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // one result bit per cycle, two radicand bits consumed
                rad_next = rad_reg << 2;
                if (srem_sh >= strial)
                begin
                    srem_next = srem_sh - strial;
                    root_next = {root_reg[qer_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh;
                    root_next = {root_reg[qer_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qer_pkg::CNT_W'(qer_pkg::SQ_N - 1))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                nump_next = {mag_p, {qer_pkg::FRAC_BITS{1'b0}}};
                numm_next = {mag_m, {qer_pkg::FRAC_BITS{1'b0}}};
                negp_next = diff_p[DW+2] ^ coef_a[DW-1];
                negm_next = diff_m[DW+2] ^ coef_a[DW-1];
                den_next  = {a_abs, 1'b0};
                remp_next = '0;
                remm_next = '0;
                cnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // both roots share the loop, quotient bits shift into the numerators
                remp_next = qp ? remp_sh - qer_pkg::DREM_W'(den_reg) : remp_sh;
                remm_next = qm ? remm_sh - qer_pkg::DREM_W'(den_reg) : remm_sh;
                nump_next = {nump_reg[qer_pkg::NUM_W-2:0], qp};
                numm_next = {numm_reg[qer_pkg::NUM_W-2:0], qm};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == qer_pkg::CNT_W'(qer_pkg::NUM_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                roots_next.plus = sat_p;
                if (dzero_reg)
                begin
                    roots_next.status    = qer_pkg::ROOTS_DOUBLE;
                    roots_next.minus     = '0;
                    roots_next.saturated = clip_p;
                end
                else
                begin
                    roots_next.status    = qer_pkg::ROOTS_TWO;
                    roots_next.minus     = sat_m;
                    roots_next.saturated = clip_p | clip_m;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = S_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            roots_reg <= '{status: qer_pkg::ROOTS_DEGEN, plus: '0, minus: '0,
                           saturated: 1'b0};
        end
        else
        begin
            state_reg <= state_next;
            roots_reg <= roots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        bb_reg    <= bb_next;
        ac_reg    <= ac_next;
        rad_reg   <= rad_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        dzero_reg <= dzero_next;
        nump_reg  <= nump_next;
        numm_reg  <= numm_next;
        remp_reg  <= remp_next;
        remm_reg  <= remm_next;
        den_reg   <= den_next;
        negp_reg  <= negp_next;
        negm_reg  <= negm_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign roots = roots_reg;

endmodule

### dv/quadratic_eval_and_roots_core_tb.sv
module quadratic_eval_and_roots_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W        = qer_pkg::DATA_WIDTH;
    localparam int XW       = 192;
    localparam int CYC_LIMIT = 400000;
    localparam logic [qer_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [XW-1:0] wide_t;

    typedef struct {
        logic signed [W-1:0] poly;
        logic                vsat;
        qer_pkg::status_t    status;
        logic signed [W-1:0] plus;
        logic signed [W-1:0] minus;
        logic                rsat;
    } quad_result_t;

    class quad_scoreboard;
        logic signed [W-1:0] coef_a;
        logic signed [W-1:0] coef_b;
        logic signed [W-1:0] coef_c;
        quad_result_t        pending_q[$];
        int                  mismatches;
        int                  results_seen;
        int                  status_seen[4];

        function new();
            coef_a = '0;
            coef_b = '0;
            coef_c = '0;
            mismatches = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_coef(logic [qer_pkg::CFG_IDX_W-1:0] idx, logic [W-1:0] data);
            if (idx == qer_pkg::REG_SQUARE) coef_a = data;
            else if (idx == qer_pkg::REG_LINEAR) coef_b = data;
            else if (idx == qer_pkg::REG_CONSTANT) coef_c = data;
        endfunction

        function logic signed [W-1:0] clip_to_range(wide_t v, inout logic clipped);
            wide_t hi;
            wide_t lo;
            hi = (wide_t'(1) <<< (W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                clipped = 1'b1;
                return hi[W-1:0];
            end
            if (v < lo)
            begin
                clipped = 1'b1;
                return lo[W-1:0];
            end
            return v[W-1:0];
        endfunction

        function wide_t floor_sqrt(wide_t n);
            wide_t r;
            wide_t cand;
            r = '0;
            for (int i = 40; i >= 0; i--)
            begin
                cand = r | (wide_t'(1) <<< i);
                if (cand * cand <= n) r = cand;
            end
            return r;
        endfunction

        function void note_x(logic signed [W-1:0] x);
            quad_result_t e;
            wide_t a, b, c, xv, sum, disc, s, den;
            a = coef_a;
            b = coef_b;
            c = coef_c;
            xv = x;
            e.vsat = 1'b0;
            e.rsat = 1'b0;
            e.plus = '0;
            e.minus = '0;
            sum = a * xv * xv + ((b * xv) <<< qer_pkg::FRAC_BITS)
                + (c <<< (2 * qer_pkg::FRAC_BITS));
            e.poly = clip_to_range(sum >>> (2 * qer_pkg::FRAC_BITS), e.vsat);
            if (a == 0)
                e.status = qer_pkg::ROOTS_DEGEN;
            else
            begin
                disc = b * b - ((a * c) <<< 2);
                if (disc < 0)
                    e.status = qer_pkg::ROOTS_NONE;
                else
                begin
                    s = floor_sqrt(disc);
                    den = a <<< 1;
                    // signed division truncates toward zero
                    e.plus = clip_to_range(((s - b) <<< qer_pkg::FRAC_BITS) / den, e.rsat);
                    if (disc == 0)
                        e.status = qer_pkg::ROOTS_DOUBLE;
                    else
                    begin
                        e.status = qer_pkg::ROOTS_TWO;
                        e.minus = clip_to_range(((-b - s) <<< qer_pkg::FRAC_BITS) / den,
                                                e.rsat);
                    end
                end
            end
            pending_q.push_back(e);
        endfunction

        function void fail_report(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_result(quad_result_t got);
            quad_result_t e;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                fail_report("result word with nothing expected");
                return;
            end
            e = pending_q.pop_front();
            status_seen[got.status]++;
            if (got.poly !== e.poly)
                fail_report($sformatf("poly_value exp %0d got %0d", e.poly, got.poly));
            if (got.vsat !== e.vsat)
                fail_report($sformatf("value_saturated exp %0b got %0b", e.vsat, got.vsat));
            if (got.status !== e.status)
                fail_report($sformatf("root_status exp %0d got %0d", e.status, got.status));
            if (got.plus !== e.plus)
                fail_report($sformatf("root_plus exp %0d got %0d", e.plus, got.plus));
            if (got.minus !== e.minus)
                fail_report($sformatf("root_minus exp %0d got %0d", e.minus, got.minus));
            if (got.rsat !== e.rsat)
                fail_report($sformatf("root_saturated exp %0b got %0b", e.rsat, got.rsat));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [qer_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [W-1:0] cfg_data;
    logic calm;
    int cycles;
    int items_sent;
    int cfg_writes;

    qer_in_if  in_ch();
    qer_out_if out_ch();

    quad_scoreboard sb;

    quadratic_eval_and_roots_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls about 11 percent of the time unless calm
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        quad_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.poly   = out_ch.poly_value;
            got.vsat   = out_ch.value_saturated;
            got.status = out_ch.root_status;
            got.plus   = out_ch.root_plus;
            got.minus  = out_ch.root_minus;
            got.rsat   = out_ch.root_saturated;
            sb.check_result(got);
        end
    end

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [qer_pkg::CFG_IDX_W-1:0] idx, logic [W-1:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_coef(idx, data);
        cfg_writes++;
        cfg_we <= 1'b0;
    endtask

    task automatic set_coefs(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
        write_reg(qer_pkg::REG_SQUARE, a);
        write_reg(qer_pkg::REG_LINEAR, b);
        write_reg(qer_pkg::REG_CONSTANT, c);
    endtask

    task automatic send_x(logic [W-1:0] x);
        in_ch.valid <= 1'b1;
        in_ch.x_value <= x;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_x(x);
        items_sent++;
        if (!calm && $urandom_range(99) < 11)
        begin
            in_ch.valid <= 1'b0;
            in_ch.x_value <= $urandom;
            @(posedge clk);
        end
    endtask

    task automatic send_directed_x();
        send_x(32'h0000_0000);
        send_x(32'h7fff_ffff);
        send_x(32'h8000_0000);
        send_x(32'hffff_ffff);
        send_x(32'h0001_0000);
        send_x(32'h0000_0001);
    endtask

    function automatic logic [W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return $urandom;
        if (pick < 8) return W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        if (pick == 8) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return '0;
    endfunction

    function automatic logic [W-1:0] rand_x();
        if ($urandom_range(1)) return $urandom;
        return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    initial
    begin
        int p, q;
        sb = new();
        rst_n = 1'b0;
        calm = 1'b0;
        cycles = 0;
        items_sent = 0;
        cfg_writes = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.x_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate case straight out of reset
        send_x(32'h0002_0000);
        send_x(32'hfffe_0000);
        // no real root: x^2 + 1
        set_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_directed_x();
        // double root: x^2 - 2x + 1
        set_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
        send_x(32'h0001_0000);
        send_x(32'h0003_0000);
        // two roots: x^2 - 1, then tiny a so roots clip
        set_coefs(32'h0001_0000, 32'h0000_0000, 32'hffff_0000);
        send_x(32'h0001_0000);
        set_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
        send_directed_x();
        set_coefs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_directed_x();
        // unused index is ignored
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_x(32'h0000_8000);

        for (int ph = 0; ph < 10; ph++)
        begin
            calm = (ph == 4);
            if (ph % 3 == 2)
            begin
                // constructed double root: a = p, b = 2pq, c = p*q*q
                p = $urandom_range(1, 255);
                if ($urandom_range(1)) p = -p;
                q = $signed($urandom_range(0, 200)) - 100;
                set_coefs(W'(p), W'(2 * p * q), W'(p * q * q));
            end
            else
                set_coefs(rand_coef(), rand_coef(), rand_coef());
            repeat (50) send_x(rand_x());
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d x words over %0d register writes, %0d results checked",
                 items_sent, cfg_writes, sb.results_seen);
        $display("root status counts: two %0d double %0d none %0d degenerate %0d",
                 sb.status_seen[qer_pkg::ROOTS_TWO], sb.status_seen[qer_pkg::ROOTS_DOUBLE],
                 sb.status_seen[qer_pkg::ROOTS_NONE], sb.status_seen[qer_pkg::ROOTS_DEGEN]);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/qer_pkg.sv
rtl/qer_in_if.sv
rtl/qer_out_if.sv
rtl/qer_solver.sv
rtl/quadratic_eval_and_roots_core.sv
dv/quadratic_eval_and_roots_core_tb.sv
